// ===== rtl/glpd_pkg.sv =====
// Package for the LZW pixel decoder: request/response structs, command and
// status codes, CSR index codes and table constants. No dependencies.
package glpd_pkg;
   localparam int MAX_CODE_BITS = 12;
   localparam int TBL_DEPTH = 4096;
   localparam int TAW = 12;
   localparam int PALETTE_DEPTH = 256;

   localparam logic [1:0] CMD_FEED = 2'd0;
   localparam logic [1:0] CMD_PULL = 2'd1;
   localparam logic [1:0] CMD_PAL = 2'd2;
   localparam logic [1:0] CMD_RESTART = 2'd3;

   localparam logic [2:0] ST_PIXEL = 3'd0;
   localparam logic [2:0] ST_TAKEN = 3'd1;
   localparam logic [2:0] ST_REFUSED = 3'd2;
   localparam logic [2:0] ST_NEED = 3'd3;
   localparam logic [2:0] ST_END = 3'd4;
   localparam logic [2:0] ST_ERR = 3'd5;
   localparam logic [2:0] ST_PALW = 3'd6;

   localparam logic [1:0] CSR_MIN = 2'd0;
   localparam logic [1:0] CSR_PSIZE = 2'd1;
   localparam logic [1:0] CSR_TEN = 2'd2;
   localparam logic [1:0] CSR_TIDX = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  data_byte;
      logic [7:0]  palette_index;
      logic [23:0] palette_rgb;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rsp_type;
endpackage

// ===== rtl/glpd_string_table.sv =====
// Prefix/suffix string table memory: one write port, one registered read.
// Depends on glpd_pkg.
module glpd_string_table (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [glpd_pkg::TAW-1:0]   wr_addr,
   input  logic [glpd_pkg::TAW+7:0]   wr_data,
   input  logic [glpd_pkg::TAW-1:0]   rd_addr,
   output logic [glpd_pkg::TAW+7:0]   rd_data
);
   logic [glpd_pkg::TAW+7:0] mem [glpd_pkg::TBL_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/glpd_pixel_stack.sv =====
// Pixel stack memory and palette memory, both one write and one registered read.
// Depends on glpd_pkg.
module glpd_pixel_stack (
   input  logic                     clock,
   input  logic                     st_we,
   input  logic [glpd_pkg::TAW-1:0] st_waddr,
   input  logic [7:0]               st_wdata,
   input  logic [glpd_pkg::TAW-1:0] st_raddr,
   output logic [7:0]               st_rdata,
   input  logic                     pal_we,
   input  logic [7:0]               pal_waddr,
   input  logic [23:0]              pal_wdata,
   input  logic [7:0]               pal_raddr,
   output logic [23:0]              pal_rdata
);
   logic [7:0]  stk [glpd_pkg::TBL_DEPTH];
   logic [23:0] pal [glpd_pkg::PALETTE_DEPTH];

   always_ff @(posedge clock) begin
      if (st_we) stk[st_waddr] <= st_wdata;
      st_rdata <= stk[st_raddr];
      if (pal_we) pal[pal_waddr] <= pal_wdata;
      pal_rdata <= pal[pal_raddr];
   end
endmodule

// ===== rtl/gif_lzw_pixel_decoder.sv =====
// GIF LZW decoder top: sequencer, bit buffer, configuration registers.
// Depends on glpd_pkg, glpd_string_table, glpd_pixel_stack.
// Feed, palette write, restart and refusals answer in the cycle after
// acceptance; a pull answering need data, end or error passes S_DEC, then S_RSP.
// A pull that pops a waiting pixel passes S_DEC, S_POP (stack read), S_PAL
// (palette read), S_RSP. A decoding pull walks the prefix chain in S_WALK,
// then pops as above, with an S_DEC pass per clear code taken; the prefix
// walk through the string-table port sets the rate. One request at a time; busy
// is high from acceptance through the strobe cycle. The receiver cannot stall.
// Reset (synchronous): decoder state to restart values, config to defaults;
// table, stack and palette memories are not cleared.
module gif_lzw_pixel_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  glpd_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output glpd_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC  = 3'd1; // decide on next code / pop
   localparam logic [2:0] S_POP  = 3'd2; // stack data ready, read palette
   localparam logic [2:0] S_PAL  = 3'd3; // palette data ready, respond
   localparam logic [2:0] S_WALK = 3'd4; // table data ready, follow chain
   localparam logic [2:0] S_RSP  = 3'd5;

   // decode phases
   localparam logic [2:0] PH_START = 3'd0;
   localparam logic [2:0] PH_FIRST = 3'd1;
   localparam logic [2:0] PH_RUN   = 3'd2;
   localparam logic [2:0] PH_FULL  = 3'd3;
   localparam logic [2:0] PH_END   = 3'd4;
   localparam logic [2:0] PH_ERR   = 3'd5;

   logic [3:0]  min_ff, min_in;
   logic [8:0]  psize_ff, psize_in;
   logic        ten_ff, ten_in;
   logic [7:0]  tidx_ff, tidx_in;

   logic [2:0]  state_ff, state_in;
   logic [18:0] bbuf_ff, bbuf_in;
   logic [4:0]  bcnt_ff, bcnt_in;
   logic [3:0]  cw_ff, cw_in;
   logic [12:0] next_ff, next_in;
   logic [11:0] prev_ff, prev_in;
   logic [7:0]  pfirst_ff, pfirst_in;
   logic [12:0] sc_ff, sc_in;
   logic [2:0]  ph_ff, ph_in;
   logic [11:0] walk_ff, walk_in;    // current code in chain walk
   logic        kw_ff, kw_in;        // walk was for out-of-table code
   logic [11:0] code_ff, code_in;    // code being expanded
   logic [7:0]  pix_ff, pix_in;
   glpd_pkg::req_type req_ff, req_in;
   glpd_pkg::rsp_type rsp_ff, rsp_in;

   // memory ports
   logic        tw_en, sw_en, pw_en;
   logic [11:0] tw_addr, tr_addr, sw_addr, sr_addr;
   logic [19:0] tw_data, tr_data;
   logic [7:0]  sw_data, sr_data, pr_addr;
   logic [23:0] pr_data;

   glpd_string_table u_tbl (
      .clock, .wr_en(tw_en), .wr_addr(tw_addr), .wr_data(tw_data),
      .rd_addr(tr_addr), .rd_data(tr_data)
   );
   glpd_pixel_stack u_stk (
      .clock, .st_we(sw_en), .st_waddr(sw_addr), .st_wdata(sw_data),
      .st_raddr(sr_addr), .st_rdata(sr_data),
      .pal_we(pw_en), .pal_waddr(req_ff.palette_index),
      .pal_wdata(req_ff.palette_rgb), .pal_raddr(pr_addr), .pal_rdata(pr_data)
   );

   logic [3:0]  fw;
   logic [11:0] code_mask, cur_code, lit_lim;
   logic [12:0] clr_code, end_code, nxt_inc;

   always_comb begin
      // first width, held at the maximum code width
      fw = ({1'b0, min_ff} + 5'd1 > 5'(glpd_pkg::MAX_CODE_BITS)) ?
           4'(glpd_pkg::MAX_CODE_BITS) : min_ff + 4'd1;
      code_mask = 12'((13'd1 << cw_ff) - 13'd1);
      cur_code = bbuf_ff[11:0] & code_mask;
      clr_code = {4'd0, psize_ff};
      end_code = clr_code + 13'd1;
      lit_lim = 12'(clr_code + 13'd2);
      nxt_inc = next_ff + 13'd1;
   end

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_data = rsp_ff;

   always_comb begin
      logic [12:0] ne;
      logic [13:0] lim;
      min_in = min_ff; psize_in = psize_ff; ten_in = ten_ff; tidx_in = tidx_ff;
      state_in = state_ff; bbuf_in = bbuf_ff; bcnt_in = bcnt_ff; cw_in = cw_ff;
      next_in = next_ff; prev_in = prev_ff; pfirst_in = pfirst_ff; sc_in = sc_ff;
      ph_in = ph_ff; walk_in = walk_ff; kw_in = kw_ff; code_in = code_ff;
      pix_in = pix_ff; req_in = req_ff; rsp_in = rsp_ff;
      tw_en = 1'b0; tw_addr = next_ff[11:0]; tw_data = {prev_ff, pfirst_ff};
      tr_addr = walk_ff; sw_en = 1'b0; sw_addr = sc_ff[11:0]; sw_data = 8'd0;
      sr_addr = 12'(sc_ff - 13'd1); pw_en = 1'b0; pr_addr = sr_data;
      ne = next_ff; lim = 14'd0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            glpd_pkg::CSR_MIN:   min_in = csr_wdata[3:0];
            glpd_pkg::CSR_PSIZE: psize_in = csr_wdata[8:0];
            glpd_pkg::CSR_TEN:   ten_in = csr_wdata[0];
            glpd_pkg::CSR_TIDX:  tidx_in = csr_wdata[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '0;
               case (req_data.cmd)
                  glpd_pkg::CMD_FEED: begin
                     if (bcnt_ff < {1'b0, cw_ff}) begin
                        bbuf_in = bbuf_ff | 19'({11'd0, req_data.data_byte} << bcnt_ff);
                        bcnt_in = bcnt_ff + 5'd8;
                        rsp_in.status = glpd_pkg::ST_TAKEN;
                     end else rsp_in.status = glpd_pkg::ST_REFUSED;
                     state_in = S_RSP;
                  end
                  glpd_pkg::CMD_PULL: state_in = S_DEC;
                  glpd_pkg::CMD_PAL: begin
                     rsp_in.status = glpd_pkg::ST_PALW;
                     state_in = S_RSP;
                  end
                  default: begin
                     bbuf_in = '0; bcnt_in = '0; sc_in = '0; prev_in = '0;
                     pfirst_in = '0; cw_in = fw; next_in = end_code + 13'd1;
                     ph_in = PH_START; rsp_in.status = glpd_pkg::ST_NEED;
                     state_in = S_RSP;
                  end
               endcase
            end
         end
         S_DEC: begin
            if (sc_ff != 13'd0) begin
               sc_in = sc_ff - 13'd1;   // read issued at sc-1
               state_in = S_POP;
            end else if (ph_ff == PH_END) begin
               rsp_in.status = glpd_pkg::ST_END; state_in = S_RSP;
            end else if (ph_ff == PH_ERR) begin
               rsp_in.status = glpd_pkg::ST_ERR; state_in = S_RSP;
            end else if (bcnt_ff < {1'b0, cw_ff}) begin
               rsp_in.status = glpd_pkg::ST_NEED; state_in = S_RSP;
            end else begin
               bbuf_in = bbuf_ff >> cw_ff;
               bcnt_in = bcnt_ff - {1'b0, cw_ff};
               if ({1'b0, cur_code} == end_code) begin
                  ph_in = PH_END; rsp_in.status = glpd_pkg::ST_END; state_in = S_RSP;
               end else if (ph_ff == PH_START || {1'b0, cur_code} == clr_code) begin
                  cw_in = fw; next_in = end_code + 13'd1; ph_in = PH_FIRST;
               end else if (ph_ff == PH_FIRST) begin
                  if ({1'b0, cur_code} >= clr_code) begin
                     ph_in = PH_ERR; rsp_in.status = glpd_pkg::ST_ERR; state_in = S_RSP;
                  end else begin
                     sw_en = 1'b1; sw_data = cur_code[7:0]; sc_in = sc_ff + 13'd1;
                     prev_in = cur_code; pfirst_in = cur_code[7:0]; ph_in = PH_RUN;
                  end
               end else if (ph_ff == PH_FULL) begin
                  ph_in = PH_ERR; rsp_in.status = glpd_pkg::ST_ERR; state_in = S_RSP;
               end else begin
                  if ({1'b0, cur_code} < next_ff) begin
                     walk_in = cur_code; kw_in = 1'b0;
                  end else begin
                     sw_en = 1'b1; sw_data = pfirst_ff; sc_in = sc_ff + 13'd1;
                     walk_in = prev_ff; kw_in = 1'b1;
                  end
                  code_in = cur_code;
                  tr_addr = walk_in;
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (walk_ff >= lit_lim && sc_ff < 13'(glpd_pkg::TBL_DEPTH)) begin
               sw_en = 1'b1; sw_data = tr_data[7:0]; sc_in = sc_ff + 13'd1;
               walk_in = tr_data[19:8]; tr_addr = tr_data[19:8];
            end else begin
               if (sc_ff < 13'(glpd_pkg::TBL_DEPTH)) begin
                  sw_en = 1'b1; sw_data = walk_ff[7:0]; sc_in = sc_ff + 13'd1;
               end
               // append previous + first index
               if (next_ff < 13'(glpd_pkg::TBL_DEPTH)) begin
                  tw_en = 1'b1; tw_data = {prev_ff, walk_ff[7:0]};
                  ne = nxt_inc;
               end
               next_in = ne;
               lim = 14'd1 << cw_ff;
               if ({1'b0, ne} >= lim) begin
                  if (cw_ff >= 4'(glpd_pkg::MAX_CODE_BITS)) ph_in = PH_FULL;
                  else cw_in = cw_ff + 4'd1;
               end
               if (!kw_ff) prev_in = code_ff;
               else if (next_ff < 13'(glpd_pkg::TBL_DEPTH)) prev_in = next_ff[11:0];
               pfirst_in = walk_ff[7:0];
               state_in = S_DEC;
            end
         end
         S_POP: begin
            pix_in = sr_data; pr_addr = sr_data; state_in = S_PAL;
         end
         S_PAL: begin
            rsp_in.status = glpd_pkg::ST_PIXEL;
            if (!(ten_ff && pix_ff == tidx_ff)) begin
               rsp_in.red = pr_data[23:16]; rsp_in.green = pr_data[15:8];
               rsp_in.blue = pr_data[7:0]; rsp_in.alpha = 8'hFF;
            end
            state_in = S_RSP;
         end
         S_RSP: begin
            if (req_ff.cmd == glpd_pkg::CMD_PAL) pw_en = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; min_ff <= 4'd8; psize_ff <= 9'd256; ten_ff <= 1'b0;
         tidx_ff <= 8'd0; bbuf_ff <= '0; bcnt_ff <= '0; cw_ff <= 4'd9;
         next_ff <= 13'd258; prev_ff <= '0; pfirst_ff <= '0; sc_ff <= '0;
         ph_ff <= PH_START;
      end else begin
         state_ff <= state_in; min_ff <= min_in; psize_ff <= psize_in;
         ten_ff <= ten_in; tidx_ff <= tidx_in; bbuf_ff <= bbuf_in;
         bcnt_ff <= bcnt_in; cw_ff <= cw_in; next_ff <= next_in;
         prev_ff <= prev_in; pfirst_ff <= pfirst_in; sc_ff <= sc_in; ph_ff <= ph_in;
      end
      walk_ff <= walk_in; kw_ff <= kw_in; code_ff <= code_in; pix_ff <= pix_in;
      req_ff <= req_in; rsp_ff <= rsp_in;
   end
endmodule
